>>> rtl/cpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpid_pkg
// Shared types and constants of the current-loop PID controller: action
// codes, register indexes, configuration record and reset values.
// ----------------------------------------------------------------------------
package cpid_pkg;

    // Build-time defaults
    localparam int ADC_BITS_DEF     = 10;
    localparam int FILTER_SHIFT_DEF = 3;

    // Fixed field widths
    localparam int ACTION_W  = 3;
    localparam int GAIN_W    = 15;
    localparam int LEVEL_W   = 10;
    localparam int DBAND_W   = 8;
    localparam int DRIVE_W   = 16;
    localparam int INTEG_W   = 15;  // holds +/-(10 * 1023)
    localparam int LIMIT_W   = 14;  // 10 * max_delta, unsigned
    localparam int Q_SHIFT   = 8;   // Q8 gains
    localparam int ZERO_RESET = 513;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7FFF;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;

    // APB
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Input actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE  = 3'd0,
        ACT_TICK    = 3'd1,
        ACT_CAL     = 3'd2,
        ACT_ENABLE  = 3'd3,
        ACT_DISABLE = 3'd4
    } t_action;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_TARGET     = 3'd3,
        REG_MAX_DELTA  = 3'd4,
        REG_SHUTOFF    = 3'd5,
        REG_DEADBAND   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LEVEL_W-1:0] target_level;
        logic [LEVEL_W-1:0] max_delta;
        logic [LEVEL_W-1:0] shutoff_delta;
        logic [DBAND_W-1:0] deadband;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        prop_gain:     15'd600,
        integ_gain:    15'd104,
        deriv_gain:    15'd208,
        target_level:  10'd513,
        max_delta:     10'd250,
        shutoff_delta: 10'd300,
        deadband:      8'd5
    };

endpackage
`default_nettype wire

>>> rtl/cpid_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpid_ifs
// Valid/ready channels of the controller: action beats in, drive beats out.
// ----------------------------------------------------------------------------
interface cpid_in_if #(
    parameter int ADC_BITS = cpid_pkg::ADC_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [cpid_pkg::ACTION_W-1:0] action;
    logic [ADC_BITS-1:0]          sample;

    modport source (output valid, action, sample, input ready);
    modport sink   (input valid, action, sample, output ready);
endinterface

interface cpid_out_if #(
    parameter int ADC_BITS = cpid_pkg::ADC_BITS_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic signed [cpid_pkg::DRIVE_W-1:0] drive;
    logic                                shutoff;
    logic                                running;
    logic [ADC_BITS-1:0]                 filtered_level;

    modport source (output valid, drive, shutoff, running, filtered_level, input ready);
    modport sink   (input valid, drive, shutoff, running, filtered_level, output ready);
endinterface
`default_nettype wire

>>> rtl/cpid_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpid_regs
// APB register file holding gains, target and thresholds. Zero-wait writes
// on the access phase, combinational read-back.
// ----------------------------------------------------------------------------
module cpid_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cpid_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [cpid_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cpid_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output cpid_pkg::t_cfg                       o_cfg
);
    import cpid_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[CFG_ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (w_wr) begin
            case (w_idx)
                REG_PROP_GAIN:  r_cfg.prop_gain     <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN: r_cfg.integ_gain    <= pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: r_cfg.deriv_gain    <= pwdata[GAIN_W-1:0];
                REG_TARGET:     r_cfg.target_level  <= pwdata[LEVEL_W-1:0];
                REG_MAX_DELTA:  r_cfg.max_delta     <= pwdata[LEVEL_W-1:0];
                REG_SHUTOFF:    r_cfg.shutoff_delta <= pwdata[LEVEL_W-1:0];
                REG_DEADBAND:   r_cfg.deadband      <= pwdata[DBAND_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        case (w_idx)
            REG_PROP_GAIN:  prdata = APB_DATA_W'(r_cfg.prop_gain);
            REG_INTEG_GAIN: prdata = APB_DATA_W'(r_cfg.integ_gain);
            REG_DERIV_GAIN: prdata = APB_DATA_W'(r_cfg.deriv_gain);
            REG_TARGET:     prdata = APB_DATA_W'(r_cfg.target_level);
            REG_MAX_DELTA:  prdata = APB_DATA_W'(r_cfg.max_delta);
            REG_SHUTOFF:    prdata = APB_DATA_W'(r_cfg.shutoff_delta);
            REG_DEADBAND:   prdata = APB_DATA_W'(r_cfg.deadband);
            default:        prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/cpid_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpid_core
// Loop state and single-pass datapath: reading filter, over-current trip,
// deadband, clamped integrator, Q8 P+I-D sum, drive hold and saturation.
// State advances on i_step; result fields are combinational.
// ----------------------------------------------------------------------------
module cpid_core #(
    parameter int ADC_BITS     = cpid_pkg::ADC_BITS_DEF,
    parameter int FILTER_SHIFT = cpid_pkg::FILTER_SHIFT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_step,
    input  wire logic [cpid_pkg::ACTION_W-1:0]        i_action,
    input  wire logic [ADC_BITS-1:0]                  i_sample,
    input  wire cpid_pkg::t_cfg                       i_cfg,
    output logic signed [cpid_pkg::DRIVE_W-1:0]       o_drive,
    output logic                                      o_shutoff,
    output logic                                      o_running,
    output logic [ADC_BITS-1:0]                       o_filtered
);
    import cpid_pkg::*;

    localparam int LW  = (ADC_BITS > LEVEL_W) ? ADC_BITS : LEVEL_W; // level width
    localparam int DW  = LW + 1;                                    // delta / error
    localparam int GW  = GAIN_W + 1;                                // signed gain
    localparam int SW  = ((INTEG_W > DW) ? INTEG_W : DW) + 1;       // integrator sum
    localparam int TPW = GW + DW;
    localparam int TIW = GW + INTEG_W;
    localparam int TDW = GW + DW + 1;
    localparam int UW  = TPW + 2;                                   // P+I-D sum

    // State
    logic [ADC_BITS-1:0]       r_filt;
    logic [LW-1:0]             r_zero;
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [DW-1:0]      r_perr;
    logic signed [DRIVE_W-1:0] r_pdrive;
    logic                      r_loop_on;

    logic [ADC_BITS:0]         w_filt_sum;
    logic signed [DW-1:0]      w_delta;
    logic [DW-1:0]             w_adelta;
    logic                      w_trip;
    logic signed [DW-1:0]      w_err_raw;
    logic signed [DW-1:0]      w_db;
    logic signed [DW-1:0]      w_err;
    logic [LIMIT_W-1:0]        w_limit;
    logic signed [SW-1:0]      w_lim_s;
    logic signed [SW-1:0]      w_isum;
    logic signed [SW-1:0]      w_iclamp;
    logic signed [INTEG_W-1:0] w_integ;
    logic signed [DW:0]        w_derr;
    logic signed [TPW-1:0]     w_tp;
    logic signed [TIW-1:0]     w_ti;
    logic signed [TIW-1:0]     w_ti_sh;
    logic signed [TDW-1:0]     w_td;
    logic signed [TDW-1:0]     w_td_sh;
    logic signed [UW-1:0]      w_sum;
    logic signed [UW-1:0]      w_u;
    logic signed [UW-1:0]      w_prev;
    logic signed [DW-1:0]      w_mx;
    logic                      w_hold;
    logic signed [UW-1:0]      w_held;
    logic signed [DRIVE_W-1:0] w_drive;

    // Exponential filter, wraps to the reading width
    assign w_filt_sum = {1'b0, r_filt} - {1'b0, (r_filt >> FILTER_SHIFT)}
                      + {1'b0, (i_sample >> FILTER_SHIFT)};

    // Offset from zero and over-current trip
    assign w_delta  = $signed({1'b0, LW'(r_filt)}) - $signed({1'b0, r_zero});
    assign w_adelta = w_delta[DW-1] ? DW'(-w_delta) : DW'(w_delta);
    assign w_trip   = (w_adelta >= DW'(i_cfg.shutoff_delta));

    // Error with deadband
    assign w_err_raw = $signed({1'b0, LW'(i_cfg.target_level)})
                     - $signed({1'b0, LW'(r_filt)});
    assign w_db      = $signed(DW'(i_cfg.deadband));
    assign w_err     = ((w_err_raw > -w_db) && (w_err_raw < w_db)) ? '0 : w_err_raw;

    // Integrator clamped to +/-(10 * max_delta)
    assign w_limit  = (LIMIT_W'(i_cfg.max_delta) << 3) + (LIMIT_W'(i_cfg.max_delta) << 1);
    assign w_lim_s  = $signed(SW'(w_limit));
    assign w_isum   = SW'(r_integ) + SW'(w_err);

    always_comb begin
        if (w_isum > w_lim_s) begin
            w_iclamp = w_lim_s;
        end else if (w_isum < -w_lim_s) begin
            w_iclamp = -w_lim_s;
        end else begin
            w_iclamp = w_isum;
        end
    end

    assign w_integ = INTEG_W'(w_iclamp);

    // P, I, D terms; I and D floor-shifted before the final Q8 shift
    assign w_derr  = (DW + 1)'(w_err) - (DW + 1)'(r_perr);
    assign w_tp    = TPW'($signed({1'b0, i_cfg.prop_gain}))  * TPW'(w_err);
    assign w_ti    = TIW'($signed({1'b0, i_cfg.integ_gain})) * TIW'(w_integ);
    assign w_td    = TDW'($signed({1'b0, i_cfg.deriv_gain})) * TDW'(w_derr);
    assign w_ti_sh = w_ti >>> Q_SHIFT;
    assign w_td_sh = w_td >>> Q_SHIFT;
    assign w_sum   = UW'(w_tp) + UW'(w_ti_sh) - UW'(w_td_sh);
    assign w_u     = w_sum >>> Q_SHIFT;

    // Hold the drive when already past max_delta and pushing further
    assign w_prev = UW'(r_pdrive);
    assign w_mx   = $signed(DW'(i_cfg.max_delta));
    assign w_hold = ((w_delta >= w_mx) && (w_prev < w_u))
                 || ((w_delta <= -w_mx) && (w_prev > w_u));
    assign w_held = w_hold ? w_prev : w_u;

    // Saturate to the drive width
    always_comb begin
        if (w_held > UW'(DRIVE_MAX)) begin
            w_drive = DRIVE_MAX;
        end else if (w_held < UW'(DRIVE_MIN)) begin
            w_drive = DRIVE_MIN;
        end else begin
            w_drive = DRIVE_W'(w_held);
        end
    end

    // Result of a tick
    assign o_drive    = (w_trip || !r_loop_on) ? '0 : w_drive;
    assign o_shutoff  = w_trip;
    assign o_running  = r_loop_on & ~w_trip;
    assign o_filtered = r_filt;

    // State update per action
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt    <= '0;
            r_zero    <= LW'(ZERO_RESET);
            r_integ   <= '0;
            r_perr    <= '0;
            r_pdrive  <= '0;
            r_loop_on <= 1'b0;
        end else if (i_step) begin
            case (i_action)
                ACT_SAMPLE: begin
                    r_filt <= w_filt_sum[ADC_BITS-1:0];
                end
                ACT_CAL: begin
                    r_zero <= LW'(r_filt);
                end
                ACT_ENABLE: begin
                    r_loop_on <= 1'b1;
                end
                ACT_DISABLE: begin
                    r_loop_on <= 1'b0;
                    r_integ   <= '0;
                    r_perr    <= '0;
                end
                ACT_TICK: begin
                    if (w_trip) begin
                        r_loop_on <= 1'b0;
                    end else if (!r_loop_on) begin
                        r_integ  <= '0;
                        r_perr   <= '0;
                        r_pdrive <= '0;
                    end else begin
                        r_integ  <= w_integ;
                        r_perr   <= w_err;
                        r_pdrive <= w_drive;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/current_loop_pid_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an accepted beat waits in the input register; once it moves on, a tick's
//   result beat is registered in the output register. Throughput: one beat per
//   cycle, set by the single-pass cpid_core, while no tick waits on the output.
// Reset: synchronous, active low; loop state and registers return to defaults
//   at once, no clearing pass.
// ----------------------------------------------------------------------------
// current_loop_pid_controller
// Current-sensor PID loop: input register, PID datapath with loop state,
// output register, and APB configuration registers.
// ----------------------------------------------------------------------------
module current_loop_pid_controller #(
    parameter int ADC_BITS     = cpid_pkg::ADC_BITS_DEF,
    parameter int FILTER_SHIFT = cpid_pkg::FILTER_SHIFT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    cpid_in_if.sink                              i_in,
    cpid_out_if.source                           o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cpid_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [cpid_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [cpid_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import cpid_pkg::*;

    t_cfg                      w_cfg;

    logic                      r_in_valid;
    logic [ACTION_W-1:0]       r_in_action;
    logic [ADC_BITS-1:0]       r_in_sample;

    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_out_drive;
    logic                      r_out_shutoff;
    logic                      r_out_running;
    logic [ADC_BITS-1:0]       r_out_filt;

    logic                      w_gives_result;
    logic                      w_out_free;
    logic                      w_advance;
    logic signed [DRIVE_W-1:0] w_drive;
    logic                      w_shutoff;
    logic                      w_running;
    logic [ADC_BITS-1:0]       w_filt;

    cpid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cpid_core #(
        .ADC_BITS     (ADC_BITS),
        .FILTER_SHIFT (FILTER_SHIFT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_action   (r_in_action),
        .i_sample   (r_in_sample),
        .i_cfg      (w_cfg),
        .o_drive    (w_drive),
        .o_shutoff  (w_shutoff),
        .o_running  (w_running),
        .o_filtered (w_filt)
    );

    // Beat in the input register moves on unless its result has nowhere to go
    assign w_gives_result = (r_in_action == ACT_TICK);
    assign w_out_free     = ~r_out_valid | o_out.ready;
    assign w_advance      = r_in_valid & (~w_gives_result | w_out_free);
    assign i_in.ready     = ~r_in_valid | w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_action <= i_in.action;
            r_in_sample <= i_in.sample;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_gives_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_gives_result) begin
            r_out_drive   <= w_drive;
            r_out_shutoff <= w_shutoff;
            r_out_running <= w_running;
            r_out_filt    <= w_filt;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.drive          = r_out_drive;
    assign o_out.shutoff        = r_out_shutoff;
    assign o_out.running        = r_out_running;
    assign o_out.filtered_level = r_out_filt;

`ifndef SYNTH
    // A trip reports zero drive and a stopped loop
    a_trip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_shutoff) |-> (r_out_drive == '0) && !r_out_running)
        else $error("shutoff beat with nonzero drive or running loop");

    // A stopped loop never drives
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_running) |-> (r_out_drive == '0))
        else $error("drive nonzero while loop not running");

    // A blocked tick stays in the input register unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=>
            (r_in_valid && $stable(r_in_action) && $stable(r_in_sample)))
        else $error("input beat lost while blocked");

    // A processed tick always lands in the output register
    a_tick_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_gives_result) |=> r_out_valid)
        else $error("tick result not registered");
`endif

endmodule
`default_nettype wire

>>> tb/sv/cpid_drive_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpid_drive_checker
// Watches the action, drive and APB ports of the current-loop PID controller.
// Keeps its own copy of the loop state and the registers, works out the drive
// beat of every accepted tick and compares each drive beat, field by field,
// with the oldest beat still outstanding.
// ----------------------------------------------------------------------------
module cpid_drive_checker #(
    parameter int FILTER_SHIFT = cpid_pkg::FILTER_SHIFT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    cpid_in_if                                   in_ch,
    cpid_out_if                                  out_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [cpid_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [cpid_pkg::APB_DATA_W-1:0] pwdata,
    output int                                   o_fail_count,
    output int                                   o_drives_seen,
    output int                                   o_drives_outstanding
);
    import cpid_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      shutoff;
        logic                      running;
        logic [LEVEL_W-1:0]        level;
    } t_drive_beat;

    t_drive_beat        pending_drives[$];

    // Mirror of the registers and the loop state
    t_cfg               cfg;
    logic [LEVEL_W-1:0] filt_level;
    logic [LEVEL_W-1:0] zero_level;
    int                 integ_acc;
    int                 last_error;
    int                 last_drive;
    bit                 loop_on;

    int                 fails = 0;
    int                 seen  = 0;

    // Apply one accepted action beat; a tick queues the drive beat it causes
    task automatic predict_drive(input logic [ACTION_W-1:0] act,
                                 input logic [LEVEL_W-1:0] smp);
        int          delta;
        int          adelta;
        int          err;
        int          lim;
        int          db;
        longint      tp;
        longint      ti;
        longint      td;
        longint      u;
        bit          shut;
        t_drive_beat beat;
        u    = 0;
        shut = 1'b0;
        case (act)
            ACT_SAMPLE: begin
                filt_level = filt_level - (filt_level >> FILTER_SHIFT)
                             + (smp >> FILTER_SHIFT);
            end
            ACT_CAL: begin
                zero_level = filt_level;
            end
            ACT_ENABLE: begin
                loop_on = 1'b1;
            end
            ACT_DISABLE: begin
                loop_on    = 1'b0;
                integ_acc  = 0;
                last_error = 0;
            end
            ACT_TICK: begin
                delta  = int'(filt_level) - int'(zero_level);
                adelta = (delta < 0) ? -delta : delta;
                if (adelta >= int'(cfg.shutoff_delta)) begin
                    // over-current trip: state kept until the next disabled tick
                    loop_on = 1'b0;
                    shut    = 1'b1;
                end else if (!loop_on) begin
                    integ_acc  = 0;
                    last_error = 0;
                    last_drive = 0;
                end else begin
                    err = int'(cfg.target_level) - int'(filt_level);
                    db  = int'(cfg.deadband);
                    if (err > -db && err < db) err = 0;
                    lim       = int'(cfg.max_delta) * 10;
                    integ_acc = integ_acc + err;
                    if (integ_acc > lim)  integ_acc = lim;
                    if (integ_acc < -lim) integ_acc = -lim;
                    // Q8 terms, shifts round toward minus infinity
                    tp = longint'(cfg.prop_gain) * err;
                    ti = (longint'(cfg.integ_gain) * integ_acc) >>> Q_SHIFT;
                    td = (longint'(cfg.deriv_gain) * (err - last_error)) >>> Q_SHIFT;
                    u  = (tp + ti - td) >>> Q_SHIFT;
                    last_error = err;
                    // hold the drive when already past max_delta from zero
                    if (delta >= int'(cfg.max_delta) && longint'(last_drive) < u)
                        u = last_drive;
                    if (delta <= -int'(cfg.max_delta) && longint'(last_drive) > u)
                        u = last_drive;
                    if (u > longint'(DRIVE_MAX)) u = longint'(DRIVE_MAX);
                    if (u < longint'(DRIVE_MIN)) u = longint'(DRIVE_MIN);
                    last_drive = int'(u);
                end
                beat.drive   = u[DRIVE_W-1:0];
                beat.shutoff = shut;
                beat.running = loop_on;
                beat.level   = filt_level;
                pending_drives.push_back(beat);
            end
            default: begin
                // unused action codes are dropped
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_drive_beat got;
        t_drive_beat want;
        if (!i_rst_n) begin
            cfg        = CFG_RESET;
            filt_level = '0;
            zero_level = LEVEL_W'(ZERO_RESET);
            integ_acc  = 0;
            last_error = 0;
            last_drive = 0;
            loop_on    = 1'b0;
            pending_drives.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[4:2]))
                    REG_PROP_GAIN:  cfg.prop_gain     = pwdata[GAIN_W-1:0];
                    REG_INTEG_GAIN: cfg.integ_gain    = pwdata[GAIN_W-1:0];
                    REG_DERIV_GAIN: cfg.deriv_gain    = pwdata[GAIN_W-1:0];
                    REG_TARGET:     cfg.target_level  = pwdata[LEVEL_W-1:0];
                    REG_MAX_DELTA:  cfg.max_delta     = pwdata[LEVEL_W-1:0];
                    REG_SHUTOFF:    cfg.shutoff_delta = pwdata[LEVEL_W-1:0];
                    REG_DEADBAND:   cfg.deadband      = pwdata[DBAND_W-1:0];
                    default: ;
                endcase
            end
            // drive beats
            if (out_ch.valid && out_ch.ready) begin
                seen++;
                got = '{out_ch.drive, out_ch.shutoff, out_ch.running,
                        out_ch.filtered_level};
                if (pending_drives.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT) begin
                        $display("[%0t] unexpected drive beat", $realtime);
                        $display("  got drive=%0d shutoff=%0b running=%0b level=%0d",
                                 got.drive, got.shutoff, got.running, got.level);
                    end
                end else begin
                    want = pending_drives.pop_front();
                    if (got.drive !== want.drive || got.shutoff !== want.shutoff ||
                        got.running !== want.running || got.level !== want.level) begin
                        fails++;
                        if (fails <= REPORT_LIMIT) begin
                            $display("[%0t] drive beat mismatch", $realtime);
                            $display("  exp drive=%0d shutoff=%0b running=%0b level=%0d",
                                     want.drive, want.shutoff, want.running,
                                     want.level);
                            $display("  got drive=%0d shutoff=%0b running=%0b level=%0d",
                                     got.drive, got.shutoff, got.running,
                                     got.level);
                        end
                    end
                end
            end
            // action beats
            if (in_ch.valid && in_ch.ready)
                predict_drive(in_ch.action, in_ch.sample);
        end
        o_fail_count         <= fails;
        o_drives_seen        <= seen;
        o_drives_outstanding <= pending_drives.size();
    end

endmodule

>>> tb/sv/current_loop_pid_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_loop_pid_controller_tb
// Drives action beats and register writes into the current-loop PID
// controller: a directed start on the corner cases, then randomized phases of
// filter samples and control ticks under changing gains and thresholds, with
// random gaps on both channels. The checker grades every drive beat.
// ----------------------------------------------------------------------------
module current_loop_pid_controller_tb;
    import cpid_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;    // covers the input and output registers
    localparam int END_CYCLES     = 8;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 70;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cpid_in_if  in_ch ();
    cpid_out_if out_ch ();

    int fail_count;
    int drives_seen;
    int drives_outstanding;
    int ticks_sent  = 0;
    int idle_cycles = 0;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;

    current_loop_pid_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cpid_drive_checker u_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .in_ch                (in_ch),
        .out_ch               (out_ch),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .pready               (pready),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .o_fail_count         (fail_count),
        .o_drives_seen        (drives_seen),
        .o_drives_outstanding (drives_outstanding)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Send one action beat after a random gap; valid stays high on acceptance
    task automatic send_beat(input logic [ACTION_W-1:0] act,
                             input logic [LEVEL_W-1:0] smp);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.sample <= smp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (act == ACT_TICK) ticks_sent++;
    endtask

    // Stop sending and wait until every tick has produced its drive beat
    task automatic drain_drives;
        in_ch.valid <= 1'b0;
        while (drives_seen < ticks_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all seven registers back to back, psel held between accesses
    task automatic write_cfg(input t_cfg c);
        t_reg_idx              idx;
        logic [APB_DATA_W-1:0] data;
        for (int i = 0; i < 7; i++) begin
            idx = t_reg_idx'(i);
            case (idx)
                REG_PROP_GAIN:  data = APB_DATA_W'(c.prop_gain);
                REG_INTEG_GAIN: data = APB_DATA_W'(c.integ_gain);
                REG_DERIV_GAIN: data = APB_DATA_W'(c.deriv_gain);
                REG_TARGET:     data = APB_DATA_W'(c.target_level);
                REG_MAX_DELTA:  data = APB_DATA_W'(c.max_delta);
                REG_SHUTOFF:    data = APB_DATA_W'(c.shutoff_delta);
                REG_DEADBAND:   data = APB_DATA_W'(c.deadband);
                default:        data = '0;
            endcase
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= data;
            @(posedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drive sink: random stall before each beat
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // Watchdog on cycles without any beat or register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_cfg cfg;
        int   center;
        int   lvl;
        int   pick;
        int   items;
        in_ch.valid  = 1'b0;
        in_ch.action = ACT_SAMPLE;
        in_ch.sample = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: trip at power-up on both first ticks, ignored codes, then
        // calibrate, enable, run a couple of ticks, disable and send a disabled tick
        tx_steady = ($urandom_range(0, 1) == 1);
        rx_steady = ($urandom_range(0, 1) == 1);
        send_beat(ACT_TICK, '0);
        send_beat(ACT_TICK, '1);
        send_beat(3'd5, '1);
        send_beat(3'd6, '0);
        send_beat(3'd7, '1);
        repeat (3) send_beat(ACT_SAMPLE, 10'h3FF);
        send_beat(ACT_CAL, '0);
        send_beat(ACT_ENABLE, '0);
        send_beat(ACT_TICK, '0);
        send_beat(ACT_SAMPLE, '0);
        send_beat(ACT_TICK, '0);
        send_beat(ACT_DISABLE, '0);
        send_beat(ACT_TICK, '0);

        // All registers at their maximum: positive saturation
        drain_drives;
        cfg = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1, target_level: '1,
                max_delta: '1, shutoff_delta: '1, deadband: '1};
        write_cfg(cfg);
        send_beat(ACT_ENABLE, '0);
        send_beat(ACT_TICK, '0);
        send_beat(ACT_SAMPLE, '0);
        send_beat(ACT_TICK, '0);

        // Zero target, zero max_delta: both hold tests at delta zero,
        // then negative saturation
        drain_drives;
        cfg = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1, target_level: '0,
                max_delta: '0, shutoff_delta: '1, deadband: '0};
        write_cfg(cfg);
        send_beat(ACT_CAL, '0);
        send_beat(ACT_ENABLE, '0);
        send_beat(ACT_TICK, '0);
        send_beat(ACT_SAMPLE, 10'h3FF);
        send_beat(ACT_TICK, '0);

        // All registers zero: shutoff threshold of zero always trips
        drain_drives;
        write_cfg('0);
        send_beat(ACT_ENABLE, '0);
        send_beat(ACT_TICK, '0);

        // Randomized phases
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_drives;
            cfg.prop_gain     = GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                             : $urandom_range(0, 32767));
            cfg.integ_gain    = GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                             : $urandom_range(0, 32767));
            cfg.deriv_gain    = GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                                                             : $urandom_range(0, 32767));
            cfg.target_level  = LEVEL_W'($urandom_range(0, 1023));
            cfg.max_delta     = LEVEL_W'(($urandom_range(0, 3) != 0)
                                         ? $urandom_range(0, 150)
                                         : $urandom_range(0, 1023));
            cfg.shutoff_delta = LEVEL_W'(($urandom_range(0, 3) != 0)
                                         ? $urandom_range(100, 1023)
                                         : $urandom_range(0, 1023));
            cfg.deadband      = DBAND_W'(($urandom_range(0, 3) != 0)
                                         ? $urandom_range(0, 20)
                                         : $urandom_range(0, 255));
            write_cfg(cfg);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            center    = $urandom_range(0, 1023);
            items     = 0;
            while (items < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                items++;
                if (pick < 50) begin
                    // samples mostly near the operating point, some anywhere
                    if ($urandom_range(0, 9) == 0) begin
                        lvl = $urandom_range(0, 1023);
                    end else begin
                        lvl = center + int'($urandom_range(0, 240)) - 120;
                        if (lvl < 0)    lvl = 0;
                        if (lvl > 1023) lvl = 1023;
                    end
                    send_beat(ACT_SAMPLE, LEVEL_W'(lvl));
                end else if (pick < 80) begin
                    send_beat(ACT_TICK, LEVEL_W'($urandom));
                end else if (pick < 89) begin
                    send_beat(ACT_ENABLE, LEVEL_W'($urandom));
                end else if (pick < 93) begin
                    send_beat(ACT_CAL, LEVEL_W'($urandom));
                end else if (pick < 96) begin
                    send_beat(ACT_DISABLE, LEVEL_W'($urandom));
                end else if (pick < 98) begin
                    // ignored codes do not count as items
                    send_beat(ACTION_W'($urandom_range(5, 7)), LEVEL_W'($urandom));
                    items--;
                end else begin
                    center = $urandom_range(0, 1023);
                    items--;
                end
            end
        end

        drain_drives;
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && drives_outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
